/* hdl/set_membership_table_assert.svh */
// ----------------------------------------------------------------------------
// Set membership table assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SET_MEMBERSHIP_TABLE_ASSERT_SVH
`define SET_MEMBERSHIP_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set membership table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set membership table assertion failed");

`endif

/* hdl/smt_pkg.sv */
// ----------------------------------------------------------------------------
// Set membership table package
// Request codes, the scan token and commit types, and fixed field widths.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int REQ_W   = 2;
  localparam int COUNT_W = 7;

  // Code 3 is unused and behaves as a query.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } smt_req_e;

  // Control part of the token that walks down the row of cells.
  typedef struct packed {
    logic     vld;
    smt_req_e req;
    logic     found;
    logic     free_found;
  } smt_tok_t;

  // Update that the controller broadcasts to the cells at the end of a scan.
  typedef struct packed {
    logic wr;
    logic clr;
  } smt_cmt_t;

  typedef struct packed {
    logic was_present;
    logic full_reject;
  } smt_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } smt_state_e;

endpackage

/* hdl/smt_if.sv */
// ----------------------------------------------------------------------------
// Set membership table channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface smt_req_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [smt_pkg::REQ_W-1:0] req_type;
  logic [ELEM_WIDTH-1:0]   element_value;

  modport source (output valid, output req_type, output element_value, input ready);
  modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface smt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        was_present;
  logic                        full_reject;
  logic [smt_pkg::COUNT_W-1:0] element_count;

  modport source (output valid, output was_present, output full_reject,
                  output element_count, input ready);
  modport sink   (input valid, input was_present, input full_reject,
                  input element_count, output ready);
endinterface

/* hdl/smt_cell.sv */
// ----------------------------------------------------------------------------
// Set membership table cell
// Holds one entry, compares it against the passing token and forwards it.
// ----------------------------------------------------------------------------
module smt_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smt_pkg::smt_tok_t     tok_i,
  input  logic [ELEM_WIDTH-1:0] val_i,
  input  logic [IDX_W-1:0]      free_idx_i,
  input  logic [IDX_W-1:0]      hit_idx_i,
  output smt_pkg::smt_tok_t     tok_o,
  output logic [ELEM_WIDTH-1:0] val_o,
  output logic [IDX_W-1:0]      free_idx_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  input  smt_pkg::smt_cmt_t     cmt_i,
  input  logic [IDX_W-1:0]      cmt_idx_i,
  input  logic [ELEM_WIDTH-1:0] cmt_val_i
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic                  valid_q, valid_d;
  logic [ELEM_WIDTH-1:0] value_q;
  smt_pkg::smt_tok_t     tok_q, tok_d;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic                  match;
  logic                  sel;

  assign match = valid_q && (value_q == val_i);
  assign sel   = (cmt_idx_i == MyIdx);

  always_comb begin
    tok_d      = tok_i;
    free_idx_d = free_idx_i;
    hit_idx_d  = hit_idx_i;
    if (match) begin
      tok_d.found = 1'b1;
      hit_idx_d   = MyIdx;
    end
    // The first free cell along the row is the lowest free entry.
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      free_idx_d       = MyIdx;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (sel && cmt_i.wr) begin
      valid_d = 1'b1;
    end else if (sel && cmt_i.clr) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmt_i.wr) begin
      value_q <= cmt_val_i;
    end
    val_q      <= val_i;
    free_idx_q <= free_idx_d;
    hit_idx_q  <= hit_idx_d;
  end

  assign tok_o      = tok_q;
  assign val_o      = val_q;
  assign free_idx_o = free_idx_q;
  assign hit_idx_o  = hit_idx_q;

endmodule

/* hdl/smt_ctrl.sv */
// ----------------------------------------------------------------------------
// Set membership table controller
// Resolves a finished scan, updates the entries and count, drives the result.
// ----------------------------------------------------------------------------
module smt_ctrl #(
  parameter int ELEM_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_accept_i,
  output logic                        in_ready_o,
  input  smt_pkg::smt_tok_t           tok_i,
  input  logic [ELEM_WIDTH-1:0]       val_i,
  input  logic [IDX_W-1:0]            free_idx_i,
  input  logic [IDX_W-1:0]            hit_idx_i,
  output smt_pkg::smt_cmt_t           cmt_o,
  output logic [IDX_W-1:0]            cmt_idx_o,
  output logic [ELEM_WIDTH-1:0]       cmt_val_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output smt_pkg::smt_res_t           out_res_o,
  output logic [smt_pkg::COUNT_W-1:0] out_count_o
);

  localparam int EXT_W = CNT_W + smt_pkg::COUNT_W;

  smt_pkg::smt_state_e         state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  smt_pkg::smt_res_t           out_res_q, out_res_d;
  logic [smt_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  smt_pkg::smt_res_t           pend_res_q, pend_res_d;
  logic [smt_pkg::COUNT_W-1:0] pend_count_q, pend_count_d;
  smt_pkg::smt_res_t           res;
  logic [EXT_W-1:0]            cnt_ext;
  logic                        out_free;

  assign out_free  = !out_valid_q || out_ready_i;
  assign cnt_ext   = EXT_W'(cnt_d);
  assign cmt_val_o = val_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_res_d    = out_res_q;
    out_count_d  = out_count_q;
    pend_res_d   = pend_res_q;
    pend_count_d = pend_count_q;
    cmt_o        = '0;
    cmt_idx_o    = hit_idx_i;
    in_ready_o   = 1'b0;
    res.was_present = tok_i.found;
    res.full_reject = 1'b0;

    if (tok_i.vld) begin
      case (tok_i.req)
        smt_pkg::REQ_ADD: begin
          if (!tok_i.found) begin
            if (tok_i.free_found) begin
              cmt_o.wr  = 1'b1;
              cmt_idx_o = free_idx_i;
              cnt_d     = cnt_q + CNT_W'(1);
            end else begin
              res.full_reject = 1'b1;
            end
          end
        end
        smt_pkg::REQ_REMOVE: begin
          if (tok_i.found) begin
            cmt_o.clr = 1'b1;
            cnt_d     = cnt_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      smt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i) begin
          state_d = smt_pkg::ST_SCAN;
        end
      end
      smt_pkg::ST_SCAN: begin
        if (tok_i.vld) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_res_d   = res;
            out_count_d = cnt_ext[smt_pkg::COUNT_W-1:0];
            state_d     = smt_pkg::ST_IDLE;
          end else begin
            pend_res_d   = res;
            pend_count_d = cnt_ext[smt_pkg::COUNT_W-1:0];
            state_d      = smt_pkg::ST_HOLD;
          end
        end
      end
      smt_pkg::ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = pend_res_q;
          out_count_d = pend_count_q;
          state_d     = smt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smt_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q    <= out_res_d;
    out_count_q  <= out_count_d;
    pend_res_q   <= pend_res_d;
    pend_count_q <= pend_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_count_o = out_count_q;

endmodule

/* hdl/set_membership_table.sv */
// ----------------------------------------------------------------------------
// Set membership table
// Bounded store of distinct values with add, remove and membership query.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                      Accepted when
//  req_i    in   req_type, element_value                      valid && ready
//  rsp_o    out  was_present, full_reject, element_count      valid && ready
//
// A request token walks the row of CAPACITY cells, one cell per cycle; the controller
// commits the update as it leaves the last cell and then offers the result, taking the
// next request from that cycle on; only one request is in the table at a time.
// Reset clears all valid marks and the count at once; no clearing pass.
// A stalled result sits in the output register while the next request scans;
// a second finished result then waits inside the block until the first leaves.
module set_membership_table #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input logic            clk_i,
  input logic            rst_ni,
  smt_req_if.sink        req_i,
  smt_rsp_if.source      rsp_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  smt_pkg::smt_tok_t     tok_w      [CAPACITY+1];
  logic [ELEM_WIDTH-1:0] val_w      [CAPACITY+1];
  logic [IDX_W-1:0]      free_idx_w [CAPACITY+1];
  logic [IDX_W-1:0]      hit_idx_w  [CAPACITY+1];

  smt_pkg::smt_cmt_t     cmt;
  logic [IDX_W-1:0]      cmt_idx;
  logic [ELEM_WIDTH-1:0] cmt_val;
  logic                  in_ready;
  logic                  in_accept;
  smt_pkg::smt_res_t     out_res;

  assign in_accept   = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  always_comb begin
    tok_w[0].vld        = in_accept;
    tok_w[0].req        = smt_pkg::smt_req_e'(req_i.req_type);
    tok_w[0].found      = 1'b0;
    tok_w[0].free_found = 1'b0;
  end

  assign val_w[0]      = req_i.element_value;
  assign free_idx_w[0] = '0;
  assign hit_idx_w[0]  = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    smt_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_w[k]),
      .val_i      (val_w[k]),
      .free_idx_i (free_idx_w[k]),
      .hit_idx_i  (hit_idx_w[k]),
      .tok_o      (tok_w[k+1]),
      .val_o      (val_w[k+1]),
      .free_idx_o (free_idx_w[k+1]),
      .hit_idx_o  (hit_idx_w[k+1]),
      .cmt_i      (cmt),
      .cmt_idx_i  (cmt_idx),
      .cmt_val_i  (cmt_val)
    );
  end

  smt_ctrl #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_ready_o  (in_ready),
    .tok_i       (tok_w[CAPACITY]),
    .val_i       (val_w[CAPACITY]),
    .free_idx_i  (free_idx_w[CAPACITY]),
    .hit_idx_i   (hit_idx_w[CAPACITY]),
    .cmt_o       (cmt),
    .cmt_idx_o   (cmt_idx),
    .cmt_val_o   (cmt_val),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_res_o   (out_res),
    .out_count_o (rsp_o.element_count)
  );

  assign rsp_o.was_present = out_res.was_present;
  assign rsp_o.full_reject = out_res.full_reject;

endmodule

/* hdl/smt_checker.sv */
// ----------------------------------------------------------------------------
// Set membership table checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_membership_table_assert.svh"

module smt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        was_present_i,
  input logic                        full_reject_i,
  input logic [smt_pkg::COUNT_W-1:0] element_count_i
);

  localparam int CAP_W = $clog2(CAPACITY + 1) + smt_pkg::COUNT_W;

  logic stalled;
  logic [CAP_W-1:0] count_ext;

  assign stalled   = out_valid_i && !out_ready_i;
  assign count_ext = CAP_W'(element_count_i);

  `SMT_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, stalled, out_valid_i)
  `SMT_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, stalled, $stable({was_present_i, full_reject_i, element_count_i}))
  `SMT_ASSERT_SAME(a_reject_only_absent, clk_i, rst_ni, out_valid_i && full_reject_i, !was_present_i)
  `SMT_ASSERT_SAME(a_count_bounded, clk_i, rst_ni, out_valid_i, count_ext <= CAP_W'(CAPACITY))
  `SMT_ASSERT_NEXT(a_one_request_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind set_membership_table smt_checker #(
  .CAPACITY (CAPACITY)
) u_smt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .was_present_i   (rsp_o.was_present),
  .full_reject_i   (rsp_o.full_reject),
  .element_count_i (rsp_o.element_count)
);

/* tb/sv/set_membership_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Set membership table testbench
// Drives add, remove and query requests through the request channel and
// checks every response against a behavioral copy of the table. A short
// table of directed requests comes first, then random sequences that fill
// the table to capacity, drain it, and mix operations on held and new
// values. Both channels idle at random, and the response side holds off
// for long stretches so the block backs up into its request channel.
// ----------------------------------------------------------------------------
module set_membership_table_tb;

  localparam int CAPACITY        = 64;
  localparam int ELEM_WIDTH      = 32;
  localparam int ITEMS_TOTAL     = 1850;
  localparam int LATENCY         = CAPACITY + 1;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int N_DIR           = 21;

  // Code 3 has no enum member; the block treats it as a query.
  localparam logic [smt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef logic [ELEM_WIDTH-1:0]     elem_t;
  typedef logic [smt_pkg::REQ_W-1:0] req_code_t;

  typedef struct packed {
    logic                        was_present;
    logic                        full_reject;
    logic [smt_pkg::COUNT_W-1:0] element_count;
  } member_result_t;

  typedef struct packed {
    req_code_t      code;
    elem_t          value;
    logic           typed;
    member_result_t want;
  } dir_row_t;

  typedef enum int {
    SEQ_FILL,
    SEQ_DRAIN,
    SEQ_MIXED,
    SEQ_NOISE
  } seq_kind_e;

  logic clk;
  logic rst_n;

  smt_req_if #(.ELEM_WIDTH(ELEM_WIDTH)) req_if ();
  smt_rsp_if                            rsp_if ();

  set_membership_table #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Behavioral copy of the table.
  elem_t            held_vals [CAPACITY];
  logic             held_mark [CAPACITY];
  int               held_total;

  member_result_t   pending_results[$];
  dir_row_t         dir_rows [N_DIR];

  int src_idle_pct;
  int sink_idle_pct;
  int hold_off_asks;
  int n_requests;
  int n_checked;
  int n_rejects;
  int n_hits;
  int n_fail;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_held(input elem_t v);
    for (int i = 0; i < CAPACITY; i++) begin
      if (held_mark[i] && held_vals[i] == v) return i;
    end
    return CAPACITY;
  endfunction

  function automatic member_result_t apply_request(input req_code_t code, input elem_t v);
    member_result_t r;
    int hit;
    int slot;
    hit = find_held(v);
    slot = CAPACITY;
    r = '0;
    r.was_present = (hit < CAPACITY);
    if (code == smt_pkg::REQ_ADD && hit == CAPACITY) begin
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if (!held_mark[i]) slot = i;
      end
      if (slot < CAPACITY) begin
        held_vals[slot] = v;
        held_mark[slot] = 1'b1;
        held_total++;
      end else begin
        r.full_reject = 1'b1;
      end
    end else if (code == smt_pkg::REQ_REMOVE && hit < CAPACITY) begin
      held_mark[hit] = 1'b0;
      held_total--;
    end
    r.element_count = held_total[smt_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Random value that the table does not hold right now.
  function automatic elem_t fresh_value();
    elem_t v;
    v = $urandom;
    while (find_held(v) < CAPACITY) v = $urandom;
    return v;
  endfunction

  // Random held value; the caller makes sure the table is not empty.
  function automatic elem_t pick_held();
    int idx;
    idx = $urandom_range(CAPACITY - 1);
    while (!held_mark[idx]) idx = (idx + 1) % CAPACITY;
    return held_vals[idx];
  endfunction

  // Biased toward values that hit: held entries and a small window at each end.
  function automatic elem_t choose_value();
    int roll;
    elem_t v;
    roll = $urandom_range(99);
    if (roll < 45 && held_total > 0) begin
      v = pick_held();
    end else if (roll < 75) begin
      v = $urandom_range(63);
      if ($urandom_range(1)) v = ~v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Offers one item, holds it until accepted, then records its expected result.
  task automatic send_request(input req_code_t code, input elem_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= code;
    req_if.element_value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_request(code, v));
    n_requests++;
  endtask

  task automatic run_sequence(input seq_kind_e kind);
    int len;
    int roll;
    req_code_t code;
    case (kind)
      SEQ_FILL: begin
        while (held_total < CAPACITY) send_request(smt_pkg::REQ_ADD, fresh_value());
        len = $urandom_range(5, 2);
        repeat (len) begin
          roll = $urandom_range(2);
          if (roll == 0) send_request(smt_pkg::REQ_ADD, fresh_value());
          else if (roll == 1) send_request(smt_pkg::REQ_ADD, pick_held());
          else send_request(smt_pkg::REQ_QUERY, choose_value());
        end
      end
      SEQ_DRAIN: begin
        len = (held_total > 0) ? $urandom_range(held_total, 1) : 4;
        repeat (len) begin
          if ($urandom_range(99) < 80) begin
            send_request(smt_pkg::REQ_REMOVE,
                         (held_total > 0) ? pick_held() : choose_value());
          end else begin
            send_request(smt_pkg::REQ_QUERY, choose_value());
          end
        end
      end
      SEQ_MIXED: begin
        len = $urandom_range(24, 8);
        repeat (len) begin
          roll = $urandom_range(99);
          if (roll < 40) code = smt_pkg::REQ_ADD;
          else if (roll < 70) code = smt_pkg::REQ_REMOVE;
          else if (roll < 95) code = smt_pkg::REQ_QUERY;
          else code = REQ_UNUSED;
          send_request(code, choose_value());
        end
      end
      default: begin
        len = $urandom_range(10, 4);
        repeat (len) send_request(req_code_t'($urandom_range(3)), elem_t'($urandom));
      end
    endcase
  endtask

  // Response side: random back-pressure, long hold-offs on request, checking.
  initial begin : response_side
    member_result_t want;
    int hold_left;
    int hold_off_seen;
    hold_left = 0;
    hold_off_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("response with no request outstanding");
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (rsp_if.was_present) n_hits++;
          if (rsp_if.full_reject) n_rejects++;
          if (rsp_if.was_present !== want.was_present) begin
            $error("was_present: expected %0d, actual %0d", want.was_present,
                   rsp_if.was_present);
            n_fail++;
          end
          if (rsp_if.full_reject !== want.full_reject) begin
            $error("full_reject: expected %0d, actual %0d", want.full_reject,
                   rsp_if.full_reject);
            n_fail++;
          end
          if (rsp_if.element_count !== want.element_count) begin
            $error("element_count: expected %0d, actual %0d", want.element_count,
                   rsp_if.element_count);
            n_fail++;
          end
        end
      end
      if (hold_off_asks != hold_off_seen) begin
        hold_off_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : request_side
    int phase;
    int random_start;
    int roll;
    for (int i = 0; i < CAPACITY; i++) begin
      held_vals[i] = '0;
      held_mark[i] = 1'b0;
    end
    held_total    = 0;
    n_requests    = 0;
    n_checked     = 0;
    n_rejects     = 0;
    n_hits        = 0;
    n_fail        = 0;
    hold_off_asks = 0;
    src_idle_pct  = 35;
    sink_idle_pct = 48;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= smt_pkg::REQ_QUERY;
    req_if.element_value <= '0;
    rst_n = 1'b0;

    dir_rows = '{
      '{smt_pkg::REQ_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{smt_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{REQ_UNUSED,          32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{smt_pkg::REQ_ADD,    32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{smt_pkg::REQ_ADD,    32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd1}},
      '{smt_pkg::REQ_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{smt_pkg::REQ_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{REQ_UNUSED,          32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{smt_pkg::REQ_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd1}},
      '{smt_pkg::REQ_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{smt_pkg::REQ_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{smt_pkg::REQ_ADD,    32'h8000_0000, 1'b0, '0},
      '{smt_pkg::REQ_ADD,    32'h0000_0001, 1'b0, '0},
      '{smt_pkg::REQ_ADD,    32'h7FFF_FFFF, 1'b0, '0},
      '{smt_pkg::REQ_ADD,    32'hAAAA_AAAA, 1'b0, '0},
      '{smt_pkg::REQ_ADD,    32'h5555_5555, 1'b0, '0},
      '{smt_pkg::REQ_QUERY,  32'h0000_0001, 1'b0, '0},
      '{smt_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
      '{smt_pkg::REQ_ADD,    32'h0000_0000, 1'b0, '0},
      '{smt_pkg::REQ_QUERY,  32'hFFFF_FFFE, 1'b0, '0},
      '{smt_pkg::REQ_REMOVE, 32'h8000_0000, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_request(dir_rows[i].code, dir_rows[i].value);
      if (dir_rows[i].typed) pending_results[pending_results.size() - 1] = dir_rows[i].want;
    end

    // The first random sequence always fills the table so that later adds can be refused.
    random_start = n_requests;
    phase = 0;
    run_sequence(SEQ_FILL);
    while (n_requests < ITEMS_TOTAL) begin
      if (phase == 0 && n_requests >= random_start + (ITEMS_TOTAL - random_start) / 3) begin
        phase = 1;
        src_idle_pct  = 48;
        sink_idle_pct = 35;
        hold_off_asks++;
      end else if (phase == 1 &&
                   n_requests >= random_start + 2 * (ITEMS_TOTAL - random_start) / 3) begin
        phase = 2;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_off_asks++;
      end
      roll = $urandom_range(99);
      if (roll < 12) run_sequence(SEQ_FILL);
      else if (roll < 27) run_sequence(SEQ_DRAIN);
      else if (roll < 85) run_sequence(SEQ_MIXED);
      else run_sequence(SEQ_NOISE);
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d requests with %0d responses checked across three idling phases.",
             n_requests, n_checked);
    $display("Responses held %0d hits on stored values and %0d adds refused at capacity.",
             n_hits, n_rejects);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/smt_pkg.sv
hdl/smt_if.sv
hdl/smt_cell.sv
hdl/smt_ctrl.sv
hdl/set_membership_table.sv
hdl/smt_checker.sv
tb/sv/set_membership_table_tb.sv
